// ----- design/swrl_pkg.sv -----
package swrl_pkg;

  // Operation codes of the input item; code three is unused
  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  // Configuration port
  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_SHORT_LIMIT = 3'd0;
  localparam logic [2:0] REG_MSG_LIMIT   = 3'd1;
  localparam logic [2:0] REG_FILE_LIMIT  = 3'd2;
  localparam logic [2:0] REG_LONG_SECS   = 3'd3;
  localparam logic [2:0] REG_SHORT_SECS  = 3'd4;

  localparam logic [4:0] RST_SHORT_LIMIT = 5'd5;
  localparam logic [4:0] RST_MSG_LIMIT   = 5'd20;
  localparam logic [4:0] RST_FILE_LIMIT  = 5'd3;
  localparam logic [7:0] RST_LONG_SECS   = 8'd10;
  localparam logic [7:0] RST_SHORT_SECS  = 8'd1;

  typedef struct packed {
    logic [4:0] short_limit;
    logic [4:0] msg_limit;
    logic [4:0] file_limit;
    logic [7:0] long_secs;
    logic [7:0] short_secs;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // take the input item, read slot table
    logic start_check;  // load ring head and fill of the selected ring
    logic clear_wr;     // clearing pass: mark one slot closed
    logic slot_wr;      // open or close the item's slot
    logic stamp_wr;     // append the time stamp
    logic rd_oldest;    // read the oldest entry
    logic prune_dec;    // drop the oldest entry, read the next one
    logic ring_wr;      // write ring head and fill back
    logic burst_first;  // read the newest entry
    logic burst_inc;    // count one burst entry, read the next older one
    logic out_load;     // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic simple;       // slot out of range or unused operation
    logic slot_op;      // open or close
    logic active;
    logic file;
    logic older_long;
    logic older_short;
    logic fill_nz;
    logic burst_last;
    logic out_busy;
  } stat_t;

endpackage

// ----- design/swrl_ctrl.sv -----
module swrl_ctrl import swrl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_META  = 8'b0000_0100,
    ST_WRITE = 8'b0000_1000,
    ST_ISSUE = 8'b0001_0000,
    ST_PRUNE = 8'b0010_0000,
    ST_BURST = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Take a new item only when idle
  assign in_stall = (state_r != ST_IDLE);

  // Sequence one item through the datapath
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_META;
        end
      end
      ST_META: begin
        if (stat.simple) begin
          state_nxt = ST_DONE;
        end else if (stat.slot_op) begin
          cmd.slot_wr = 1'b1;
          state_nxt   = ST_DONE;
        end else if (!stat.active) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.start_check = 1'b1;
          state_nxt       = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.stamp_wr = 1'b1;
        state_nxt    = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.rd_oldest = 1'b1;
        state_nxt     = ST_PRUNE;
      end
      ST_PRUNE: begin
        if (stat.fill_nz && stat.older_long) begin
          cmd.prune_dec = 1'b1;
        end else begin
          cmd.ring_wr = 1'b1;
          if (stat.file || !stat.fill_nz) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.burst_first = 1'b1;
            state_nxt       = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (!stat.older_short) begin
          cmd.burst_inc = 1'b1;
        end
        if (stat.older_short || stat.burst_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/swrl_dp.sv -----
module swrl_dp import swrl_pkg::*; #(
  parameter int NUM_SLOTS     = 16,
  parameter int HISTORY_DEPTH = 32,
  parameter int TIME_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_client_slot,
  input  logic        in_is_file,
  input  logic [31:0] in_now_seconds,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_allowed,
  output logic [5:0]  out_window_count,
  output logic [5:0]  out_burst_count
);

  localparam int SB          = $clog2(NUM_SLOTS);
  localparam int SXW         = ((SB > 4) ? SB : 4) + 1;
  localparam int HB          = $clog2(HISTORY_DEPTH);
  localparam int FB          = $clog2(HISTORY_DEPTH + 1);
  localparam int PW          = HB + 2;
  localparam int TW          = TIME_BITS;
  localparam int STAMP_DEPTH = 2 * NUM_SLOTS * HISTORY_DEPTH;
  localparam int SAW         = $clog2(STAMP_DEPTH);
  localparam int CW          = (FB > 5) ? FB : 5;

  typedef struct packed {
    logic          active;
    logic [HB-1:0] head1;
    logic [FB-1:0] fill1;
    logic [HB-1:0] head0;
    logic [FB-1:0] fill0;
  } meta_t;

  // Item registers
  logic [1:0]    op_r;
  logic [SB-1:0] slot_r;
  logic          slot_ok_r;
  logic          file_r;
  logic [TW-1:0] now_r;

  logic [SXW-1:0] slot_ext;
  logic [63:0]    now_ext;

  assign slot_ext = SXW'(in_client_slot);
  assign now_ext  = 64'(in_now_seconds);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_operation;
      slot_r    <= slot_ext[SB-1:0];
      slot_ok_r <= (slot_ext < SXW'(NUM_SLOTS));
      file_r    <= in_is_file;
      now_r     <= now_ext[TW-1:0];
    end
  end

  // Slot table: open flag and both ring pointers per slot
  meta_t         meta_mem [NUM_SLOTS];
  meta_t         meta_rd_r;
  meta_t         meta_wdata;
  logic [SB-1:0] meta_waddr;
  logic          meta_we;
  logic [SB-1:0] clr_idx_r;

  logic [HB-1:0] head_r;
  logic [FB-1:0] fill_r;
  logic [FB-1:0] burst_r;
  logic [HB-1:0] ptr_r;
  logic          live_r;
  logic [SAW-1:0] ring_base_r;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = slot_r;
    meta_wdata = meta_rd_r;
    if (cmd.clear_wr) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx_r;
      meta_wdata = '0;
    end else if (cmd.slot_wr) begin
      meta_we           = 1'b1;
      meta_wdata        = '0;
      meta_wdata.active = (op_r == OP_OPEN);
    end else if (cmd.ring_wr) begin
      meta_we = 1'b1;
      if (file_r) begin
        meta_wdata.head1 = head_r;
        meta_wdata.fill1 = fill_r;
      end else begin
        meta_wdata.head0 = head_r;
        meta_wdata.fill0 = fill_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.capture) begin
      meta_rd_r <= meta_mem[slot_ext[SB-1:0]];
    end
  end

  // Advance the clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx_r <= clr_idx_r + SB'(1);
    end
  end

  // Ring position arithmetic
  logic [HB-1:0] head_inc;
  logic [PW-1:0] oldest_sum;
  logic [HB-1:0] oldest_pos;
  logic [HB-1:0] ptr_nxt;
  logic          rd_en;

  assign head_inc   = (head_r == HB'(HISTORY_DEPTH - 1)) ? '0 : head_r + HB'(1);
  assign oldest_sum = PW'(head_r) + PW'(HISTORY_DEPTH) - PW'(fill_r);
  assign oldest_pos = (oldest_sum >= PW'(HISTORY_DEPTH)) ?
                      HB'(oldest_sum - PW'(HISTORY_DEPTH)) : HB'(oldest_sum);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.rd_oldest) begin
      ptr_nxt = oldest_pos;
    end else if (cmd.prune_dec) begin
      ptr_nxt = (ptr_r == HB'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + HB'(1);
    end else if (cmd.burst_first) begin
      ptr_nxt = (head_r == '0) ? HB'(HISTORY_DEPTH - 1) : head_r - HB'(1);
    end else if (cmd.burst_inc) begin
      ptr_nxt = (ptr_r == '0) ? HB'(HISTORY_DEPTH - 1) : ptr_r - HB'(1);
    end
  end

  assign rd_en = cmd.rd_oldest | cmd.prune_dec | cmd.burst_first | cmd.burst_inc;

  // Working registers of the check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (cmd.capture) begin
      live_r <= 1'b0;
    end else if (cmd.start_check) begin
      live_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      burst_r <= '0;
    end else if (cmd.burst_inc) begin
      burst_r <= burst_r + FB'(1);
    end
    if (cmd.start_check) begin
      head_r      <= file_r ? meta_rd_r.head1 : meta_rd_r.head0;
      fill_r      <= file_r ? meta_rd_r.fill1 : meta_rd_r.fill0;
      ring_base_r <= SAW'({slot_r, file_r}) * SAW'(HISTORY_DEPTH);
    end else if (cmd.stamp_wr) begin
      head_r <= head_inc;
      if (fill_r != FB'(HISTORY_DEPTH)) begin
        fill_r <= fill_r + FB'(1);
      end
    end else if (cmd.prune_dec) begin
      fill_r <= fill_r - FB'(1);
    end
    if (rd_en) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Time stamp store
  logic [TW-1:0] stamp_mem [STAMP_DEPTH];
  logic [TW-1:0] stamp_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.stamp_wr) begin
      stamp_mem[ring_base_r + SAW'(head_r)] <= now_r;
    end
    if (rd_en) begin
      stamp_rd_r <= stamp_mem[ring_base_r + SAW'(ptr_nxt)];
    end
  end

  // Age compares against both windows
  logic [TW-1:0] span_long;
  logic [TW-1:0] span_short;

  assign span_long  = TW'(cfg.long_secs);
  assign span_short = TW'(cfg.short_secs);

  assign stat.older_long  = (now_r >= span_long) && (stamp_rd_r < now_r - span_long);
  assign stat.older_short = (now_r >= span_short) && (stamp_rd_r < now_r - span_short);
  assign stat.clear_last  = (clr_idx_r == SB'(NUM_SLOTS - 1));
  assign stat.simple      = !slot_ok_r || !(op_r inside {OP_CHECK, OP_OPEN, OP_CLOSE});
  assign stat.slot_op     = (op_r inside {OP_OPEN, OP_CLOSE});
  assign stat.active      = meta_rd_r.active;
  assign stat.file        = file_r;
  assign stat.fill_nz     = (fill_r != '0);
  assign stat.burst_last  = ((burst_r + FB'(1)) == fill_r);
  assign stat.out_busy    = out_valid && out_stall;

  // Result register
  logic allowed_nxt;

  always_comb begin
    allowed_nxt = 1'b1;
    if (live_r) begin
      if (file_r) begin
        allowed_nxt = !(CW'(fill_r) > CW'(cfg.file_limit));
      end else begin
        allowed_nxt = !((CW'(fill_r) > CW'(cfg.msg_limit)) ||
                        (CW'(burst_r) > CW'(cfg.short_limit)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_allowed      <= allowed_nxt;
      out_window_count <= live_r ? 6'(fill_r) : 6'd0;
      out_burst_count  <= 6'(burst_r);
    end
  end

  // A new result never replaces one still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten before transfer");

  // Stamps go only into rings of an open slot
  a_stamp_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stamp_wr |-> meta_rd_r.active)
    else $error("stamp written for a closed slot");

  // The entry just appended is never old, so pruning keeps it
  a_keep_newest: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prune_dec |-> (fill_r > FB'(1)))
    else $error("pruning removed the newest entry");

  // The burst count stays within the ring fill
  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r |-> (burst_r <= fill_r))
    else $error("burst count beyond ring fill");

endmodule

// ----- design/sliding_window_rate_limiter.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_operation, in_client_slot, in_is_file, in_now_seconds
// out       out_valid / out_stall  out_allowed, out_window_count, out_burst_count
// cfg       psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item at a time. Open, close, unused codes and checks on a closed slot go
// straight from the slot table read to the result. A check appends its stamp, reads
// the oldest entry, prunes entries older than the long window and, for messages,
// walks the entries for the burst count; pruned and walked entries together never
// exceed the ring fill, and each is one read on the single stamp memory read port.
// After reset a clearing pass closes all slots, one by one, with in_stall high.
// A result waits in the output register under out_stall; the next item is taken
// meanwhile and holds in its last step until the register frees.
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int NUM_SLOTS     = 16,
  parameter int HISTORY_DEPTH = 32,
  parameter int TIME_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_client_slot,
  input  logic               in_is_file,
  input  logic [31:0]        in_now_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_allowed,
  output logic [5:0]         out_window_count,
  output logic [5:0]         out_burst_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg_r, cfg_nxt;
  cmd_t  cmd;
  stat_t stat;

  logic [2:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  // Register write on the access cycle
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SHORT_LIMIT: cfg_nxt.short_limit = pwdata[4:0];
        REG_MSG_LIMIT:   cfg_nxt.msg_limit   = pwdata[4:0];
        REG_FILE_LIMIT:  cfg_nxt.file_limit  = pwdata[4:0];
        REG_LONG_SECS:   cfg_nxt.long_secs   = pwdata[7:0];
        REG_SHORT_SECS:  cfg_nxt.short_secs  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_limit <= RST_SHORT_LIMIT;
      cfg_r.msg_limit   <= RST_MSG_LIMIT;
      cfg_r.file_limit  <= RST_FILE_LIMIT;
      cfg_r.long_secs   <= RST_LONG_SECS;
      cfg_r.short_secs  <= RST_SHORT_SECS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      REG_SHORT_LIMIT: prdata = 32'(cfg_r.short_limit);
      REG_MSG_LIMIT:   prdata = 32'(cfg_r.msg_limit);
      REG_FILE_LIMIT:  prdata = 32'(cfg_r.file_limit);
      REG_LONG_SECS:   prdata = 32'(cfg_r.long_secs);
      REG_SHORT_SECS:  prdata = 32'(cfg_r.short_secs);
      default:         prdata = '0;
    endcase
  end

  swrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swrl_dp #(
    .NUM_SLOTS     (NUM_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_client_slot   (in_client_slot),
    .in_is_file       (in_is_file),
    .in_now_seconds   (in_now_seconds),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_allowed      (out_allowed),
    .out_window_count (out_window_count),
    .out_burst_count  (out_burst_count)
  );

endmodule
